@@ design/rc4_pkg.sv @@
`default_nettype none
package rc4_pkg;

  localparam int unsigned PermSize = 256;
  localparam int unsigned PermAw   = 8;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef logic [PermAw-1:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TXT_J,
    ST_TXT_T,
    ST_KS_RD,
    ST_KS_ACC,
    ST_KS_WR
  } state_e;

  // one read and one write port on the permutation RAM, clr resets it to identity
  typedef struct packed {
    logic  re;
    byte_t raddr;
    logic  we;
    byte_t waddr;
    byte_t wdata;
    logic  clr;
  } perm_req_t;

endpackage
`default_nettype wire

@@ design/rc4_perm_ram.sv @@
`default_nettype none
module rc4_perm_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc4_pkg::perm_req_t req_i,
  output rc4_pkg::byte_t    rdata_o
);
  import rc4_pkg::*;

  byte_t               mem [PermSize];
  logic [PermSize-1:0] vld_q;
  byte_t               mem_q;
  byte_t               byp_q;
  byte_t               ra_q;
  logic                byp_sel_q;
  logic                vld_sel_q;
  logic                wr_en;
  logic                hit;

  assign wr_en = req_i.we && !req_i.clr;
  assign hit   = wr_en && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      mem_q <= mem[req_i.raddr];
      byp_q <= req_i.wdata;
      ra_q  <= req_i.raddr;
    end
  end

  // invalid entry reads as its own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      byp_sel_q <= 1'b0;
      vld_sel_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        byp_sel_q <= hit;
        vld_sel_q <= !req_i.clr && vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = byp_sel_q ? byp_q : (vld_sel_q ? mem_q : ra_q);

endmodule
`default_nettype wire

@@ design/rc4_key_ram.sv @@
`default_nettype none
module rc4_key_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  rc4_pkg::byte_t wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output rc4_pkg::byte_t rdata_o
);
  import rc4_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ design/rc4_seq.sv @@
`default_nettype none
module rc4_seq #(
  parameter int unsigned KEY_MAX_BYTES = 256,
  parameter int unsigned KEY_AW        = 8,
  parameter int unsigned KEY_CW        = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic               s_kind_i,
  input  rc4_pkg::byte_t     s_byte_i,
  input  logic               s_last_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output rc4_pkg::byte_t     m_byte_o,
  output logic               m_last_o,
  output rc4_pkg::perm_req_t perm_req_o,
  input  rc4_pkg::byte_t     perm_rdata_i,
  output logic               key_we_o,
  output logic [KEY_AW-1:0]  key_waddr_o,
  output logic               key_re_o,
  output logic [KEY_AW-1:0]  key_raddr_o,
  input  rc4_pkg::byte_t     key_rdata_i
);
  import rc4_pkg::*;

  state_e            state_q, state_d;
  byte_t             i_q, i_d;
  byte_t             j_q, j_d;
  byte_t             si_q, si_d;
  byte_t             byte_q, byte_d;
  logic              last_q, last_d;
  logic              res_pend_q, res_pend_d;
  logic              ks_fwd_q, ks_fwd_d;
  byte_t             ksv_q, ksv_d;
  byte_t             k_q, k_d;
  byte_t             acc_q, acc_d;
  logic [KEY_AW-1:0] kidx_q, kidx_d;
  byte_t             sk_q, sk_d;
  logic [KEY_CW-1:0] kcnt_q, kcnt_d;
  logic              pend_v_q, pend_v_d;
  byte_t             pend_a_q, pend_a_d;
  byte_t             pend_w_q, pend_w_d;
  logic              m_valid_q, m_valid_d;
  byte_t             m_byte_q, m_byte_d;
  logic              m_last_q, m_last_d;

  logic              out_free;
  logic              accept;
  byte_t             ks;
  byte_t             t_idx;
  byte_t             jn;
  byte_t             accn;
  logic [KEY_CW-1:0] key_len;

  assign out_free = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) && (!res_pend_q || out_free);
  assign accept   = s_valid_i && s_ready_o;
  assign ks       = ks_fwd_q ? ksv_q : perm_rdata_i;
  assign t_idx    = si_q + perm_rdata_i;
  assign jn       = j_q + perm_rdata_i;
  assign accn     = acc_q + perm_rdata_i + key_rdata_i;
  assign key_len  = (kcnt_q == '0) ? KEY_CW'(1) : kcnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_kind_i == KIND_TEXT) begin
            state_d = ST_TXT_J;
          end else if (s_last_i) begin
            state_d = ST_KS_RD;
          end
        end
      end
      ST_TXT_J:  state_d = ST_TXT_T;
      ST_TXT_T:  state_d = ST_IDLE;
      ST_KS_RD:  state_d = ST_KS_ACC;
      ST_KS_ACC: state_d = ST_KS_WR;
      ST_KS_WR: begin
        state_d = (k_q == '1) ? ST_IDLE : ST_KS_RD;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    i_d        = i_q;
    j_d        = j_q;
    si_d       = si_q;
    byte_d     = byte_q;
    last_d     = last_q;
    res_pend_d = res_pend_q;
    ks_fwd_d   = ks_fwd_q;
    ksv_d      = ksv_q;
    k_d        = k_q;
    acc_d      = acc_q;
    kidx_d     = kidx_q;
    sk_d       = sk_q;
    kcnt_d     = kcnt_q;
    pend_v_d   = pend_v_q;
    pend_a_d   = pend_a_q;
    pend_w_d   = pend_w_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    m_byte_d   = m_byte_q;
    m_last_d   = m_last_q;
    perm_req_o = '0;
    key_we_o   = 1'b0;
    key_waddr_o = kcnt_q[KEY_AW-1:0];
    key_re_o   = 1'b0;
    key_raddr_o = kidx_q;

    case (state_q)
      ST_IDLE: begin
        if (pend_v_q) begin
          perm_req_o.we    = 1'b1;
          perm_req_o.waddr = pend_a_q;
          perm_req_o.wdata = pend_w_q;
          pend_v_d         = 1'b0;
        end
        if (res_pend_q && out_free) begin
          m_valid_d  = 1'b1;
          m_byte_d   = byte_q ^ ks;
          m_last_d   = last_q;
          res_pend_d = 1'b0;
        end
        if (accept) begin
          if (s_kind_i == KIND_TEXT) begin
            i_d              = i_q + 8'd1;
            perm_req_o.re    = 1'b1;
            perm_req_o.raddr = i_q + 8'd1;
            byte_d           = s_byte_i;
            last_d           = s_last_i;
          end else begin
            if (kcnt_q < KEY_CW'(KEY_MAX_BYTES)) begin
              key_we_o = 1'b1;
              kcnt_d   = kcnt_q + KEY_CW'(1);
            end
            if (s_last_i) begin
              perm_req_o.clr = 1'b1;
              k_d            = '0;
              acc_d          = '0;
              kidx_d         = '0;
            end
          end
        end
      end
      ST_TXT_J: begin
        si_d             = perm_rdata_i;
        j_d              = jn;
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = jn;
      end
      ST_TXT_T: begin
        // S[i] <- S[j] now, S[j] <- S[i] next cycle; S[t] forwarded if it hits either
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = i_q;
        perm_req_o.wdata = perm_rdata_i;
        pend_v_d         = 1'b1;
        pend_a_d         = j_q;
        pend_w_d         = si_q;
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = t_idx;
        ks_fwd_d         = (t_idx == i_q) || (t_idx == j_q);
        ksv_d            = (t_idx == i_q) ? perm_rdata_i : si_q;
        res_pend_d       = 1'b1;
      end
      ST_KS_RD: begin
        if (pend_v_q) begin
          perm_req_o.we    = 1'b1;
          perm_req_o.waddr = pend_a_q;
          perm_req_o.wdata = pend_w_q;
          pend_v_d         = 1'b0;
        end
        key_re_o         = 1'b1;
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = k_q;
      end
      ST_KS_ACC: begin
        sk_d             = perm_rdata_i;
        acc_d            = accn;
        perm_req_o.re    = 1'b1;
        perm_req_o.raddr = accn;
        if ((KEY_CW'(kidx_q) + KEY_CW'(1)) == key_len) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KEY_AW'(1);
        end
      end
      ST_KS_WR: begin
        perm_req_o.we    = 1'b1;
        perm_req_o.waddr = k_q;
        perm_req_o.wdata = perm_rdata_i;
        pend_v_d         = 1'b1;
        pend_a_d         = acc_q;
        pend_w_d         = sk_q;
        k_d              = k_q + 8'd1;
        if (k_q == '1) begin
          i_d    = '0;
          j_d    = '0;
          kcnt_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      res_pend_q <= 1'b0;
      kcnt_q     <= '0;
      pend_v_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      res_pend_q <= res_pend_d;
      kcnt_q     <= kcnt_d;
      pend_v_q   <= pend_v_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q     <= si_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
    ks_fwd_q <= ks_fwd_d;
    ksv_q    <= ksv_d;
    k_q      <= k_d;
    acc_q    <= acc_d;
    kidx_q   <= kidx_d;
    sk_q     <= sk_d;
    pend_a_q <= pend_a_d;
    pend_w_q <= pend_w_d;
    m_byte_q <= m_byte_d;
    m_last_q <= m_last_d;
  end

  assign m_valid_o = m_valid_q;
  assign m_byte_o  = m_byte_q;
  assign m_last_o  = m_last_q;

endmodule
`default_nettype wire

@@ design/rc4_keystream_cipher.sv @@
`default_nettype none
// channel  | dir | tdata          | tuser   | tlast
// s_axis   | in  | [7:0] byte_in  | [0] kind| last
// m_axis   | out | [7:0] byte_out | -       | last_out
//
// Text word: reads of S[i], S[j], S[t] in turn on the one read port of the
// permutation RAM; the result enters the output register once that is free.
// Key word: stored in the key RAM; the last one starts the 256-entry key schedule.
// Reset brings the permutation to identity at once (per-entry valid bits).
// s_axis_tready drops outside idle, and while a result waits and the output register is full.
module rc4_keystream_cipher #(
  parameter int unsigned KEY_MAX_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] byte_in
  input  wire logic       s_axis_tuser,  // [0] kind
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] byte_out
  output logic            m_axis_tlast
);
  import rc4_pkg::*;

  localparam int unsigned KeyAw = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int unsigned KeyCw = $clog2(KEY_MAX_BYTES + 1);

  perm_req_t         perm_req;
  byte_t             perm_rdata;
  logic              key_we;
  logic [KeyAw-1:0]  key_waddr;
  logic              key_re;
  logic [KeyAw-1:0]  key_raddr;
  byte_t             key_rdata;

  rc4_perm_ram u_perm_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (perm_req),
    .rdata_o(perm_rdata)
  );

  rc4_key_ram #(
    .DEPTH(KEY_MAX_BYTES),
    .AW   (KeyAw)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(s_axis_tdata),
    .re_i   (key_re),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  rc4_seq #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES),
    .KEY_AW       (KeyAw),
    .KEY_CW       (KeyCw)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_kind_i    (s_axis_tuser),
    .s_byte_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .perm_req_o  (perm_req),
    .perm_rdata_i(perm_rdata),
    .key_we_o    (key_we),
    .key_waddr_o (key_waddr),
    .key_re_o    (key_re),
    .key_raddr_o (key_raddr),
    .key_rdata_i (key_rdata)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import rc4_pkg::*;

  localparam int unsigned KeyMax      = 256;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 3 * PermSize + 32;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    byte_t data;
    logic  last;
  } cipher_word_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] byte_in
  logic       s_axis_tuser  = KIND_KEY;  // [0] kind
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;  // [7:0] byte_out
  logic       m_axis_tlast;

  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 73;
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;

  // cipher state mirror
  byte_t       perm_state [PermSize];
  byte_t       key_bytes  [KeyMax];
  int unsigned key_len;
  byte_t       gen_i;
  byte_t       gen_j;

  cipher_word_t cipher_expected [$];

  rc4_keystream_cipher #(
    .KEY_MAX_BYTES(KeyMax)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic void perm_swap(byte_t a, byte_t b);
    byte_t tmp;
    tmp = perm_state[a];
    perm_state[a] = perm_state[b];
    perm_state[b] = tmp;
  endfunction

  function automatic void cipher_init();
    for (int k = 0; k < PermSize; k++) begin
      perm_state[k] = byte_t'(k);
    end
    for (int k = 0; k < KeyMax; k++) begin
      key_bytes[k] = '0;
    end
    key_len = 0;
    gen_i   = '0;
    gen_j   = '0;
  endfunction

  function automatic void key_schedule();
    byte_t       acc;
    int unsigned len;
    acc = '0;
    len = (key_len == 0) ? 1 : key_len;
    for (int k = 0; k < PermSize; k++) begin
      perm_state[k] = byte_t'(k);
    end
    for (int k = 0; k < PermSize; k++) begin
      acc = acc + perm_state[k] + key_bytes[k % len];
      perm_swap(byte_t'(k), acc);
    end
    gen_i   = '0;
    gen_j   = '0;
    key_len = 0;
  endfunction

  function automatic void key_absorb(byte_t b, logic last);
    if (key_len < KeyMax) begin
      key_bytes[key_len] = b;
      key_len++;
    end
    if (last) key_schedule();
  endfunction

  function automatic byte_t keystream_next();
    byte_t t;
    gen_i = gen_i + 8'd1;
    gen_j = gen_j + perm_state[gen_i];
    perm_swap(gen_i, gen_j);
    t = perm_state[gen_i] + perm_state[gen_j];
    return perm_state[t];
  endfunction

  // output side: random stalls, in-order compare
  always @(posedge clk_i) begin
    cipher_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportMax) begin
          $display("unexpected output word: data %02h last %0b", m_axis_tdata, m_axis_tlast);
        end
      end else begin
        want = cipher_expected.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax) begin
            $display("mismatch: expected data %02h last %0b, got data %02h last %0b",
                     want.data, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_word(input logic kind, input byte_t data, input logic last);
    cipher_word_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    if (kind == KIND_TEXT) begin
      res.data = data ^ keystream_next();
      res.last = last;
      cipher_expected.push_back(res);
    end else begin
      key_absorb(data, last);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (cipher_expected.size() != 0);
  endtask

  task automatic send_key(input int unsigned len, input logic finish);
    for (int unsigned k = 0; k < len; k++) begin
      send_word(KIND_KEY, byte_t'($urandom), finish && (k == len - 1));
    end
  endtask

  task automatic send_text(input int unsigned len, input logic noisy_last);
    for (int unsigned k = 0; k < len; k++) begin
      send_word(KIND_TEXT, byte_t'($urandom),
                noisy_last ? logic'($urandom_range(0, 1)) : (k == len - 1));
    end
  endtask

  task automatic test_text_before_key();
    send_word(KIND_TEXT, 8'h00, 1'b0);
    send_word(KIND_TEXT, 8'hFF, 1'b1);
    send_word(KIND_TEXT, 8'hA5, 1'b0);
  endtask

  task automatic test_single_byte_keys();
    send_word(KIND_KEY, 8'h00, 1'b1);
    send_word(KIND_TEXT, 8'hFF, 1'b0);
    send_word(KIND_TEXT, 8'h00, 1'b1);
    // rekey right after a schedule, no text between
    send_word(KIND_KEY, 8'hFF, 1'b1);
    send_word(KIND_KEY, 8'h80, 1'b1);
    send_word(KIND_TEXT, 8'h5A, 1'b1);
  endtask

  task automatic test_known_key();
    byte_t key_txt [3]  = '{8'h4B, 8'h65, 8'h79};
    byte_t plain   [9]  = '{8'h50, 8'h6C, 8'h61, 8'h69, 8'h6E, 8'h74, 8'h65, 8'h78, 8'h74};
    for (int k = 0; k < 3; k++) begin
      send_word(KIND_KEY, key_txt[k], k == 2);
    end
    for (int k = 0; k < 9; k++) begin
      send_word(KIND_TEXT, plain[k], k == 8);
    end
    wait_drained();
  endtask

  task automatic test_key_overflow();
    send_key(KeyMax, 1'b1);
    send_text(4, 1'b0);
    // last flag lands on a byte past the store depth
    send_key(KeyMax + 44, 1'b1);
    send_text(4, 1'b0);
    send_key(KeyMax + 1, 1'b1);
    send_text(2, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = words_sent + n_items;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(0, 99);
        if (len < 70) len = $urandom_range(1, 16);
        else if (len < 97) len = $urandom_range(17, 64);
        else len = $urandom_range(200, KeyMax + 4);
        send_key(len, 1'b1);
        send_text($urandom_range(1, 32), 1'b0);
      end else if (pick < 90) begin
        send_text($urandom_range(1, 16), 1'b1);
      end else begin
        // partial key, then text on the old permutation
        send_key($urandom_range(1, 8), 1'b0);
        send_text($urandom_range(1, 8), 1'b1);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  initial begin
    cipher_init();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 73;
    test_text_before_key();
    wait_drained();
    test_single_byte_keys();
    test_known_key();
    test_key_overflow();
    test_random_traffic(360);

    send_idle_pct = 73;
    recv_idle_pct = 27;
    test_random_traffic(360);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(360);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && cipher_expected.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
